// ----- src/aarm_pkg.sv -----
// Shared constants, types and functions for the axis-angle rotation matrix block.
package aarm_pkg;

    localparam int ITER_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF   = 14;
    localparam int IQ              = 30;
    localparam int AW              = 16;
    localparam int OW              = 16;

    // Q30 internal width with headroom for CORDIC growth.
    localparam int QW = 34;

    localparam logic signed [QW-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [QW-1:0] ONE_Q        = 34'sd1073741824;

    // Arctangent table, 2^32 per turn.
    function automatic logic signed [QW-1:0] atan_entry(input int i);
        logic signed [QW-1:0] t [0:29];
        t = '{34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
              34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
              34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
              34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430,
              34'sd5215, 34'sd2608, 34'sd1304, 34'sd652, 34'sd326, 34'sd163,
              34'sd81, 34'sd41, 34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1};
        return t[i];
    endfunction

    // Floor-shift a Q30 product and truncate it to the internal width.
    function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        return QW'(p >>> IQ);
    endfunction

    typedef struct packed {
        logic [AW-1:0]        angle;
        logic signed [AW-1:0] axis_x;
        logic signed [AW-1:0] axis_y;
        logic signed [AW-1:0] axis_z;
    } t_in;

    typedef struct packed {
        logic signed [OW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    } t_out;

endpackage

// ----- src/aarm_if.sv -----
// Valid/ready stream interface used for both channels.
interface aarm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/aarm_cordic.sv -----
// Pipelined rotation-mode CORDIC producing cosine and sine in Q30.
module aarm_cordic #(
    parameter int ITER_STAGES = aarm_pkg::ITER_STAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [aarm_pkg::AW-1:0]          i_angle,
    output logic signed [aarm_pkg::QW-1:0]   o_cos,
    output logic signed [aarm_pkg::QW-1:0]   o_sin
);
    import aarm_pkg::*;

    localparam int N = (ITER_STAGES < 30) ? ITER_STAGES : 30;

    logic signed [QW-1:0] r_x [0:N];
    logic signed [QW-1:0] r_y [0:N];
    logic signed [QW-1:0] r_z [0:N];
    logic [1:0]           r_q [0:N];
    logic signed [QW-1:0] cx, cy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_START;
            r_y[0] <= '0;
            r_z[0] <= QW'({i_angle[13:0], 16'd0});
            r_q[0] <= i_angle[15:14];
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][QW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_entry(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_entry(i);
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    always_comb begin
        cx = (r_x[N] > ONE_Q) ? ONE_Q : ((r_x[N] < -ONE_Q) ? -ONE_Q : r_x[N]);
        cy = (r_y[N] > ONE_Q) ? ONE_Q : ((r_y[N] < -ONE_Q) ? -ONE_Q : r_y[N]);
        case (r_q[N])
            2'd0:    begin o_cos = cx;  o_sin = cy;  end
            2'd1:    begin o_cos = -cy; o_sin = cx;  end
            2'd2:    begin o_cos = -cx; o_sin = -cy; end
            default: begin o_cos = cy;  o_sin = -cx; end
        endcase
    end
endmodule

// ----- src/aarm_norm.sv -----
// Pipelined axis normalization: squared length, square root, three divisions.
module aarm_norm #(
    parameter int LAT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [aarm_pkg::AW-1:0]  i_x,
    input  logic signed [aarm_pkg::AW-1:0]  i_y,
    input  logic signed [aarm_pkg::AW-1:0]  i_z,
    output logic signed [aarm_pkg::QW-1:0]  o_ux,
    output logic signed [aarm_pkg::QW-1:0]  o_uy,
    output logic signed [aarm_pkg::QW-1:0]  o_uz
);
    import aarm_pkg::*;

    // Square root of S*2^32 (S < 2^32) fits 32 bits; radicand 64 bits, 2 bits a stage.
    localparam int RB = 32;
    // Quotient mag*2^46/q is clamped at 2^30; 31 quotient bits, one a stage.
    localparam int DB = 31;
    localparam int SQ = RB;
    localparam int TOT = 1 + SQ + DB;
    // Delay to line up with the sine/cosine path.
    localparam int PAD = (LAT > TOT) ? LAT - TOT : 0;

    logic [31:0] r_s;
    logic [15:0] r_m0 [0:2];
    logic [2:0]  r_g0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= 32'(34'(i_x * i_x) + 34'(i_y * i_y) + 34'(i_z * i_z));
            r_m0[0] <= i_x[AW-1] ? 16'(-i_x) : 16'(i_x);
            r_m0[1] <= i_y[AW-1] ? 16'(-i_y) : 16'(i_y);
            r_m0[2] <= i_z[AW-1] ? 16'(-i_z) : 16'(i_z);
            r_g0 <= {i_z[AW-1], i_y[AW-1], i_x[AW-1]};
        end
    end

    // Restoring square root, one result bit per stage.
    logic [65:0] r_rem [0:SQ];
    logic [31:0] r_rt  [0:SQ];
    logic [63:0] r_rad [0:SQ];
    logic [15:0] r_ms  [0:SQ][0:2];
    logic [2:0]  r_gs  [0:SQ];

    always_comb begin
        r_rem[0] = '0;
        r_rt[0]  = '0;
        r_rad[0] = {r_s, 32'd0};
        r_ms[0]  = r_m0;
        r_gs[0]  = r_g0;
    end

    for (genvar i = 0; i < SQ; i++) begin : g_sq
        logic [65:0] rem2, trial;
        always_comb begin
            rem2  = {r_rem[i][63:0], r_rad[i][63:62]};
            trial = {32'd0, r_rt[i], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem2 >= trial) begin
                    r_rem[i+1] <= rem2 - trial;
                    r_rt[i+1]  <= {r_rt[i][30:0], 1'b1};
                end else begin
                    r_rem[i+1] <= rem2;
                    r_rt[i+1]  <= {r_rt[i][30:0], 1'b0};
                end
                r_rad[i+1] <= {r_rad[i][61:0], 2'b00};
                r_ms[i+1]  <= r_ms[i];
                r_gs[i+1]  <= r_gs[i];
            end
        end
    end

    // Restoring division of mag*2^46 by q, quotient bits 30 down to 0.
    // Bits above 30 mean the quotient exceeds 2^30 and clamps.
    logic [47:0] r_rm [0:DB][0:2];
    logic [30:0] r_qt [0:DB][0:2];
    logic        r_ov [0:DB][0:2];
    logic [31:0] r_dv [0:DB];
    logic [2:0]  r_gd [0:DB];

    for (genvar c = 0; c < 3; c++) begin : g_c0
        // Start: remainder = mag*2^15 (the bits above the quotient window).
        always_comb begin
            r_rm[0][c] = {17'd0, r_ms[SQ][c], 15'd0};
            r_qt[0][c] = '0;
            // Quotient >= 2^31 when mag*2^15 >= q.
            r_ov[0][c] = ({16'd0, r_ms[SQ][c], 15'd0} >= {15'd0, r_rt[SQ]});
        end
    end
    always_comb begin
        r_dv[0] = r_rt[SQ];
        r_gd[0] = r_gs[SQ];
    end

    for (genvar i = 0; i < DB; i++) begin : g_dv
        for (genvar c = 0; c < 3; c++) begin : g_c
            logic [48:0] nr;
            always_comb nr = {r_rm[i][c], 1'b0};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (nr >= {17'd0, r_dv[i]}) begin
                        r_rm[i+1][c] <= 48'(nr - {17'd0, r_dv[i]});
                        r_qt[i+1][c] <= {r_qt[i][c][29:0], 1'b1};
                    end else begin
                        r_rm[i+1][c] <= 48'(nr);
                        r_qt[i+1][c] <= {r_qt[i][c][29:0], 1'b0};
                    end
                    r_ov[i+1][c] <= r_ov[i][c];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[i+1] <= r_dv[i];
                r_gd[i+1] <= r_gd[i];
            end
        end
    end

    logic signed [QW-1:0] u [0:2];
    logic signed [QW-1:0] r_pad [0:PAD][0:2];

    for (genvar c = 0; c < 3; c++) begin : g_out
        logic [QW-1:0] mag;
        always_comb begin
            mag = (r_ov[DB][c] || r_qt[DB][c][30] && (r_qt[DB][c][29:0] != '0))
                ? ONE_Q : QW'(r_qt[DB][c]);
            u[c] = r_gd[DB][c] ? -$signed(mag) : $signed(mag);
            r_pad[0][c] = u[c];
        end
    end

    for (genvar p = 0; p < PAD; p++) begin : g_pad
        always_ff @(posedge i_clk) begin
            if (i_en) r_pad[p+1] <= r_pad[p];
        end
    end

    assign o_ux = r_pad[PAD][0];
    assign o_uy = r_pad[PAD][1];
    assign o_uz = r_pad[PAD][2];
endmodule

// ----- src/axis_angle_rotation_matrix.sv -----
// Top level of the axis-angle to rotation matrix pipeline.
// Path: the normalizer's square root and division chain, always longer than the
// CORDIC, sets the delay and feeds stages A, B and C; C is the result register.
// Throughput: one item per cycle; the whole pipeline advances whenever the result
// register is empty or being taken.
// Reset: i_rst_n (synchronous, active low) clears all valid bits; data
// registers are not reset.
module axis_angle_rotation_matrix #(
    parameter int ITER_STAGES = aarm_pkg::ITER_STAGES_DEF,
    parameter int FRAC_BITS   = aarm_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    aarm_if.sink   i_in,
    aarm_if.source o_out
);
    import aarm_pkg::*;

    localparam int NC  = (ITER_STAGES < 30) ? ITER_STAGES : 30;
    localparam int CL  = NC + 1;           // CORDIC latency
    localparam int NL  = 64;               // normalizer latency: input register, square root, division
    localparam int FL  = (CL > NL) ? CL : NL;
    localparam int CP  = FL - CL;          // padding on the sine/cosine side
    // Normalizer output sits in stage FL-1; stages A, B and C follow.
    localparam int TOT = FL + 2;
    localparam int SH  = IQ - FRAC_BITS;

    // The whole pipeline moves as one when the output register can take an item.
    logic en;
    logic [TOT:0] r_v;
    logic [TOT-1:0] r_zero;
    assign en = !r_v[TOT] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[TOT-1:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero <= {r_zero[TOT-2:0],
                (i_in.data.axis_x == '0) && (i_in.data.axis_y == '0) &&
                (i_in.data.axis_z == '0)};
        end
    end

    logic signed [QW-1:0] cs0, sn0, ux, uy, uz;

    aarm_cordic #(.ITER_STAGES(ITER_STAGES)) u_cordic (
        .i_clk(i_clk), .i_en(en), .i_angle(i_in.data.angle),
        .o_cos(cs0), .o_sin(sn0));

    aarm_norm #(.LAT(FL)) u_norm (
        .i_clk(i_clk), .i_en(en),
        .i_x(i_in.data.axis_x), .i_y(i_in.data.axis_y), .i_z(i_in.data.axis_z),
        .o_ux(ux), .o_uy(uy), .o_uz(uz));

    // Sine and cosine wait for the longer normalizer path.
    logic signed [QW-1:0] r_cp [0:CP];
    logic signed [QW-1:0] r_sp [0:CP];
    assign r_cp[0] = cs0;
    assign r_sp[0] = sn0;
    for (genvar p = 0; p < CP; p++) begin : g_cp
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cp[p+1] <= r_cp[p];
                r_sp[p+1] <= r_sp[p];
            end
        end
    end

    // Stage A: t*u and s*u, one multiplier each.
    logic signed [QW-1:0] r_c1, r_ux1, r_uy1, r_uz1;
    logic signed [QW-1:0] r_tx, r_ty, r_tz, r_sx, r_sy, r_sz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx <= qmul(ONE_Q - r_cp[CP], ux);
            r_ty <= qmul(ONE_Q - r_cp[CP], uy);
            r_tz <= qmul(ONE_Q - r_cp[CP], uz);
            r_sx <= qmul(r_sp[CP], ux);
            r_sy <= qmul(r_sp[CP], uy);
            r_sz <= qmul(r_sp[CP], uz);
            r_c1 <= r_cp[CP];
            r_ux1 <= ux;
            r_uy1 <= uy;
            r_uz1 <= uz;
        end
    end

    // Stage B: second products and sums.
    logic signed [QW-1:0] r_m [0:8];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m[0] <= qmul(r_tx, r_ux1) + r_c1;
            r_m[1] <= qmul(r_tx, r_uy1) - r_sz;
            r_m[2] <= qmul(r_tx, r_uz1) + r_sy;
            r_m[3] <= qmul(r_tx, r_uy1) + r_sz;
            r_m[4] <= qmul(r_ty, r_uy1) + r_c1;
            r_m[5] <= qmul(r_ty, r_uz1) - r_sx;
            r_m[6] <= qmul(r_tx, r_uz1) - r_sy;
            r_m[7] <= qmul(r_ty, r_uz1) + r_sx;
            r_m[8] <= qmul(r_tz, r_uz1) + r_c1;
        end
    end

    // Stage C: round, clamp, or substitute the identity for a zero axis.
    function automatic logic signed [OW-1:0] to_out(input logic signed [QW-1:0] v);
        logic signed [QW:0] r;
        logic signed [QW:0] lim;
        r = (SH > 0) ? (($signed({v[QW-1], v}) + (QW+1)'(1 << (SH-1))) >>> SH)
                     : $signed({v[QW-1], v});
        lim = (QW+1)'(1 << FRAC_BITS);
        if (lim > 32767) lim = 32767;
        if (r > lim) r = lim;
        if (r < -$signed((QW+1)'(1 << FRAC_BITS))) r = -$signed((QW+1)'(1 << FRAC_BITS));
        if (r < -32768) r = -32768;
        return OW'(r);
    endfunction

    t_out r_res;
    logic signed [OW-1:0] one_o;
    assign one_o = to_out(ONE_Q);
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_zero[TOT-1]) begin
                r_res <= '{one_o, '0, '0, '0, one_o, '0, '0, '0, one_o};
            end else begin
                r_res <= '{to_out(r_m[0]), to_out(r_m[1]), to_out(r_m[2]),
                           to_out(r_m[3]), to_out(r_m[4]), to_out(r_m[5]),
                           to_out(r_m[6]), to_out(r_m[7]), to_out(r_m[8])};
            end
        end
    end

    assign o_out.valid = r_v[TOT];
    assign o_out.data  = r_res;
endmodule

// ----- src/aarm_checker.sv -----
// Port-level checker for the rotation matrix block, with its bind.
module aarm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic i_ready,
    input logic o_valid,
    input logic o_ready,
    input logic [143:0] o_data
);
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_data))
        else $error("stalled item changed");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> i_ready)
        else $error("input blocked with empty output");
    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ready |-> i_ready)
        else $error("input blocked while output drains");
endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_valid(i_in.valid), .i_ready(i_in.ready),
    .o_valid(o_out.valid), .o_ready(o_out.ready), .o_data(o_out.data));
